// File: rtl/core/htk_pkg.sv
// ----------------------------------------------------------------------------
// htk_pkg
// Shared types, codes and per-byte parse functions of the HTTP request
// header tokenizer.
// ----------------------------------------------------------------------------
package htk_pkg;

  localparam int MAX_HEADERS = 64;
  localparam int HcntW       = $clog2(MAX_HEADERS + 1);
  localparam int SlotW       = 6;

  // line phase codes
  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_DROP    = 4'd1;
  localparam logic [3:0] PH_URI     = 4'd2;
  localparam logic [3:0] PH_QUERY   = 4'd3;
  localparam logic [3:0] PH_HTTP    = 4'd4;
  localparam logic [3:0] PH_VERSION = 4'd5;
  localparam logic [3:0] PH_NAME    = 4'd6;
  localparam logic [3:0] PH_COLON   = 4'd7;
  localparam logic [3:0] PH_VALUE   = 4'd8;
  localparam logic [3:0] PH_BODY    = 4'd9;

  // field kinds
  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_URI     = 3'd1;
  localparam logic [2:0] K_QUERY   = 3'd2;
  localparam logic [2:0] K_VERSION = 3'd3;
  localparam logic [2:0] K_HNAME   = 3'd4;
  localparam logic [2:0] K_HVALUE  = 3'd5;
  localparam logic [2:0] K_BODY    = 3'd6;

  // method codes
  localparam logic [2:0] M_NONE    = 3'd0;
  localparam logic [2:0] M_GET     = 3'd1;
  localparam logic [2:0] M_HEAD    = 3'd2;
  localparam logic [2:0] M_POST    = 3'd3;
  localparam logic [2:0] M_PUT     = 3'd4;
  localparam logic [2:0] M_OPTIONS = 3'd5;
  localparam logic [2:0] M_DELETE  = 3'd6;

  // parse status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_LF    = 3'd1;
  localparam logic [2:0] ST_NUL      = 3'd2;
  localparam logic [2:0] ST_NO_METH  = 3'd3;
  localparam logic [2:0] ST_NO_SPACE = 3'd4;
  localparam logic [2:0] ST_NO_HTTP  = 3'd5;
  localparam logic [2:0] ST_NO_COLON = 3'd6;
  localparam logic [2:0] ST_FULL     = 3'd7;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    logic [3:0]       phase;
    logic [2:0]       mpos;
    logic [2:0]       mseen;
    logic             held_cr;
    logic             line_has;
    logic [HcntW-1:0] hcnt;
    logic [2:0]       err;
    logic             done;
  } st_t;

  typedef struct packed {
    logic             v;
    logic [7:0]       data;
    logic [2:0]       kind;
    logic [SlotW-1:0] slot;
  } emit_t;

  typedef struct packed {
    st_t   st;
    emit_t e;
  } disp_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic [2:0]       field_kind;
    logic [SlotW-1:0] header_slot;
    logic [2:0]       method_code;
    logic [2:0]       parse_status;
    logic             request_done;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  function automatic logic [7:0] method_char(logic [2:0] ms, logic [2:0] pos);
    logic [55:0] txt;
    unique case (ms)
      M_GET:     txt = {"GET", 32'h0};
      M_HEAD:    txt = {"HEAD", 24'h0};
      M_POST:    txt = {"POST", 24'h0};
      M_PUT:     txt = {"PUT", 32'h0};
      M_OPTIONS: txt = "OPTIONS";
      M_DELETE:  txt = {"DELETE", 8'h0};
      default:   txt = '0;
    endcase
    if (pos == 3'd7) return CH_NUL;
    return txt[8*(6-pos) +: 8];
  endfunction

  function automatic logic [2:0] method_len(logic [2:0] ms);
    logic [2:0] len;
    unique case (ms)
      M_GET:     len = 3'd3;
      M_HEAD:    len = 3'd4;
      M_POST:    len = 3'd4;
      M_PUT:     len = 3'd3;
      M_OPTIONS: len = 3'd7;
      M_DELETE:  len = 3'd6;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] http_char(logic [2:0] pos);
    logic [39:0] txt;
    txt = "HTTP/";
    if (pos >= 3'd5) return CH_NUL;
    return txt[8*(4-pos) +: 8];
  endfunction

  // first error wins
  function automatic st_t htk_fail(st_t s, logic [2:0] code);
    st_t r;
    r = s;
    if (!s.done) begin
      r.err  = code;
      r.done = 1'b1;
    end
    return r;
  endfunction

  function automatic st_t end_header_line(st_t s);
    st_t r;
    r = s;
    if (s.hcnt < HcntW'(MAX_HEADERS)) r.hcnt = s.hcnt + 1'b1;
    r.phase    = PH_NAME;
    r.line_has = 1'b0;
    return r;
  endfunction

  function automatic disp_t htk_dispatch(st_t s, logic [7:0] c);
    disp_t      r;
    logic       go;
    logic [2:0] mp_n;
    r      = '0;
    r.st   = s;
    r.e.data = c;
    go     = 1'b1;
    mp_n   = s.mpos + 1'b1;
    if (c == CH_NUL) begin
      r.st = htk_fail(s, ST_NUL);
    end else begin
      unique case (s.phase)
        PH_METHOD: begin
          if (s.mpos == 3'd0) begin
            priority if (c == CH_LF) begin
              r.st.phase = PH_BODY;
              go = 1'b0;
            end else if (c == "G") r.st.mseen = M_GET;
            else if (c == "H") r.st.mseen = M_HEAD;
            else if (c == "P") r.st.mseen = M_POST;
            else if (c == "O") r.st.mseen = M_OPTIONS;
            else if (c == "D") r.st.mseen = M_DELETE;
            else begin
              r.st = htk_fail(r.st, ST_NO_METH);
              go = 1'b0;
            end
          end else begin
            if (s.mseen == M_POST && s.mpos == 3'd1 && c == "U") r.st.mseen = M_PUT;
            if (c != method_char(r.st.mseen, s.mpos)) begin
              r.st = htk_fail(r.st, ST_NO_METH);
              go = 1'b0;
            end
          end
          if (go) begin
            if (mp_n >= method_len(r.st.mseen)) begin
              r.st.phase = PH_DROP;
              r.st.mpos  = 3'd0;
            end else begin
              r.st.mpos = mp_n;
            end
          end
        end
        PH_DROP: begin
          if (c == CH_LF) r.st = htk_fail(s, ST_NO_SPACE);
          else r.st.phase = PH_URI;
        end
        PH_URI, PH_QUERY: begin
          priority if (c == CH_LF) begin
            r.st = htk_fail(s, ST_NO_SPACE);
          end else if (c == CH_SP) begin
            r.st.phase = PH_HTTP;
            r.st.mpos  = 3'd0;
          end else if (c == CH_QMARK && s.phase == PH_URI) begin
            r.st.phase = PH_QUERY;
          end else begin
            r.e.v    = 1'b1;
            r.e.kind = (s.phase == PH_URI) ? K_URI : K_QUERY;
          end
        end
        PH_HTTP: begin
          if (s.mpos >= 3'd5 || c != http_char(s.mpos)) begin
            r.st = htk_fail(s, ST_NO_HTTP);
          end else if (mp_n >= 3'd5) begin
            r.st.phase = PH_VERSION;
            r.st.mpos  = 3'd0;
          end else begin
            r.st.mpos = mp_n;
          end
        end
        PH_VERSION: begin
          if (c == CH_LF) begin
            r.st.phase    = PH_NAME;
            r.st.line_has = 1'b0;
          end else begin
            r.e.v    = 1'b1;
            r.e.kind = K_VERSION;
          end
        end
        PH_NAME: begin
          priority if (c == CH_LF) begin
            if (!s.line_has) r.st.phase = PH_BODY;
            else r.st = htk_fail(s, ST_NO_COLON);
          end else if (!s.line_has && s.hcnt >= HcntW'(MAX_HEADERS)) begin
            r.st = htk_fail(s, ST_FULL);
          end else begin
            r.st.line_has = 1'b1;
            if (c == CH_COLON) begin
              r.st.phase = PH_COLON;
            end else begin
              r.e.v    = 1'b1;
              r.e.kind = K_HNAME;
              r.e.slot = s.hcnt[SlotW-1:0];
            end
          end
        end
        PH_COLON: begin
          priority if (c == CH_LF) begin
            r.st = end_header_line(s);
          end else if (c == CH_SP) begin
            r.st.phase = PH_VALUE;
          end else begin
            r.st.phase = PH_VALUE;
            r.e.v    = 1'b1;
            r.e.kind = K_HVALUE;
            r.e.slot = s.hcnt[SlotW-1:0];
          end
        end
        PH_VALUE: begin
          if (c == CH_LF) begin
            r.st = end_header_line(s);
          end else begin
            r.e.v    = 1'b1;
            r.e.kind = K_HVALUE;
            r.e.slot = s.hcnt[SlotW-1:0];
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // body bytes pass, CR is held, the rest goes to the line parser
  function automatic disp_t htk_feed(st_t s, logic [7:0] c);
    disp_t r;
    r = '0;
    r.st = s;
    priority if (s.phase == PH_BODY) begin
      r.e.v    = 1'b1;
      r.e.data = c;
      r.e.kind = K_BODY;
    end else if (c == CH_CR) begin
      r.st.held_cr = 1'b1;
    end else begin
      r = htk_dispatch(s, c);
    end
    return r;
  endfunction

  function automatic res_t mk_res(emit_t e, logic [2:0] mcode);
    res_t r;
    r              = '0;
    r.out_byte     = e.data;
    r.field_kind   = e.kind;
    r.header_slot  = e.slot;
    r.method_code  = mcode;
    return r;
  endfunction

endpackage

// File: rtl/core/htk_core.sv
// ----------------------------------------------------------------------------
// htk_core
// Parser state and the single-pass byte step: up to two results per byte.
// ----------------------------------------------------------------------------
module htk_core import htk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       eom_i,
  output step_out_t  step_o
);

  st_t st_q, st_d;

  always_comb begin
    st_t        s;
    disp_t      d1, d2;
    logic       held_path;
    logic [2:0] mcode;
    res_t       r0, r1;
    logic [1:0] n;

    s  = st_q;
    d2 = '0;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    held_path = st_q.held_cr && (st_q.phase != PH_BODY);
    s.held_cr = 1'b0;

    // held CR: dropped before LF, else parsed as a byte ahead of this one
    if (held_path) begin
      d1 = htk_dispatch(s, (byte_i == CH_LF) ? CH_LF : CH_CR);
      d2.st = d1.st;
      if (byte_i != CH_LF && !d1.st.done) d2 = htk_feed(d1.st, byte_i);
    end else begin
      d1 = htk_feed(s, byte_i);
      d2.st = d1.st;
    end
    s = d2.st;

    if (eom_i && !s.done) begin
      if (s.phase == PH_BODY) s.done = 1'b1;
      else s = htk_fail(s, ST_NO_LF);
    end

    mcode = (s.phase == PH_METHOD) ? M_NONE : s.mseen;

    if (d1.e.v) begin
      r0 = mk_res(d1.e, mcode);
      if (d2.e.v) begin
        r1 = mk_res(d2.e, mcode);
        n  = 2'd2;
      end else begin
        n = 2'd1;
      end
    end else if (d2.e.v) begin
      r0 = mk_res(d2.e, mcode);
      n  = 2'd1;
    end

    // parsing ended without a byte: carry the status on an empty result
    if (s.done && n == 2'd0) begin
      r0.method_code = mcode;
      n = 2'd1;
    end

    if (n == 2'd2) begin
      r1.last_of_run  = 1'b1;
      r1.request_done = s.done;
      r1.parse_status = s.done ? s.err : ST_OK;
    end else begin
      r0.last_of_run  = 1'b1;
      r0.request_done = s.done;
      r0.parse_status = s.done ? s.err : ST_OK;
    end

    // finished request: ignore input until reset
    if (st_q.done) begin
      n = 2'd0;
      s = st_q;
    end

    st_d       = s;
    step_o.cnt = n;
    step_o.r0  = r0;
    step_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // all-zero state is the method phase with nothing matched
      st_q <= '0;
    end else if (take_i) begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/core/htk_outq.sv
// ----------------------------------------------------------------------------
// htk_outq
// Two-entry result register; loads a byte's results, drains one per beat.
// ----------------------------------------------------------------------------
module htk_outq import htk_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_out_t step_i,
  output logic      can_take_o,
  output logic      valid_o,
  input  logic      ready_i,
  output res_t      data_o
);

  logic [1:0] cnt_q, cnt_d;
  res_t       head_q, head_d;
  res_t       tail_q, tail_d;
  logic       pop;

  assign valid_o    = (cnt_q != 2'd0);
  assign data_o     = head_q;
  assign pop        = valid_o && ready_i;
  // a new load must find the queue empty after this beat
  assign can_take_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (push_i) begin
      cnt_d  = step_i.cnt;
      head_d = step_i.r0;
      tail_d = step_i.r1;
    end else if (pop) begin
      cnt_d  = cnt_q - 2'd1;
      head_d = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// File: rtl/core/http_request_header_tokenizer.sv
// ----------------------------------------------------------------------------
// http_request_header_tokenizer
// Splits an HTTP request byte stream into tagged URI, query, version,
// header name, header value and body bytes, with method and parse status.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Transaction
// s_axis    in   one request byte; tlast marks the final byte of the message
// m_axis    out  one tagged byte (or an empty status beat); tuser is the
//                field kind, tlast the last beat caused by an input byte
//
// Each byte is registered at the input, parsed combinationally and loaded into a
// two-entry result register; a byte enters every cycle unless m_axis stalls and
// yields at most one beat, except a byte that releases a held CR, which can yield
// two beats and holds off the next byte until the second beat drains.
// Reset clears parser state and empties both registers; m_axis stalls reach s_axis
// tready. After the request ends, bytes are accepted and dropped until reset.
//
module http_request_header_tokenizer import htk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [13:8] header_slot, [16:14] method_code,
  // [19:17] parse_status, [20] request_done, [23:21] zero
  output logic [23:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // field_kind
  output logic        m_axis_tlast    // last_of_run
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eom_q;

  logic       take;      // input register moves into the parser this cycle
  logic       can_take;
  step_out_t  step;
  res_t       res;

  assign take          = in_valid_q && can_take;
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eom_q  <= s_axis_tlast;
    end
  end

  // parser: state update and results for one byte
  htk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (in_byte_q),
    .eom_i  (in_eom_q),
    .step_o (step)
  );

  // result register, drained one beat at a time
  htk_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .step_i     (step),
    .can_take_o (can_take),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (res)
  );

  assign m_axis_tdata = {3'b000, res.request_done, res.parse_status, res.method_code,
                         res.header_slot, res.out_byte};
  assign m_axis_tuser = res.field_kind;
  assign m_axis_tlast = res.last_of_run;

endmodule
